// ----- rtl/core/text_command_line_parser_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the text command line parser
// Shared helpers for concurrent checks under the active-low reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_COMMAND_LINE_PARSER_MACROS_SVH
`define TEXT_COMMAND_LINE_PARSER_MACROS_SVH

// Condition holds on every clock edge out of reset
`define TLP_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define TLP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent
`define TLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/tlp_pkg.sv -----
// ----------------------------------------------------------------------------
// tlp_pkg
// Types, constants and keyword tables of the text command line parser.
// ----------------------------------------------------------------------------
package tlp_pkg;

  // Line length limit; lines of this many bytes or more are rejected
  localparam int MAX_LINE = 100;
  localparam int LEN_W    = $clog2(MAX_LINE + 1);

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Keyword lengths
  localparam int STOP_LEN = 4;
  localparam int BATT_LEN = 7;
  localparam int DIST_LEN = 8;

  // Magnitude limits for the number
  localparam logic [35:0] LIMIT_POS = 36'd2147483647;
  localparam logic [35:0] LIMIT_NEG = 36'd2147483648;

  // Character classes set by the front
  typedef enum logic [2:0] {
    CLS_TEXT  = 3'd0,
    CLS_DIGIT = 3'd1,
    CLS_BLANK = 3'd2,
    CLS_SIGN  = 3'd3,
    CLS_NUL   = 3'd4,
    CLS_EOL   = 3'd5,
    CLS_CR    = 3'd6
  } char_cls_e;

  typedef struct packed {
    char_cls_e   cls;
    logic [7:0]  ch;
  } token_t;

  // Result codes
  typedef enum logic [2:0] {
    CMD_STOP     = 3'd0,
    CMD_BATTERY  = 3'd1,
    CMD_DISTANCE = 3'd2,
    CMD_MOVE     = 3'd3,
    CMD_TURN     = 3'd4,
    CMD_DELAY    = 3'd5,
    CMD_UNKNOWN  = 3'd6,
    CMD_OVERLONG = 3'd7
  } cmd_e;

  // Prefix kinds
  localparam logic [1:0] PFX_MOVE  = 2'd0;
  localparam logic [1:0] PFX_TURN  = 2'd1;
  localparam logic [1:0] PFX_DELAY = 2'd2;

  // Number parser state
  typedef enum logic [5:0] {
    PH_PREFIX = 6'b000001,
    PH_BLANKS = 6'b000010,
    PH_SIGNED = 6'b000100,
    PH_DIGITS = 6'b001000,
    PH_DONE   = 6'b010000,
    PH_FAIL   = 6'b100000
  } phase_e;

  function automatic logic [7:0] stop_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = "S";
      3'd1:    c = "t";
      3'd2:    c = "o";
      default: c = "p";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] batt_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = "B";
      3'd1:    c = "a";
      3'd2:    c = "t";
      3'd3:    c = "t";
      3'd4:    c = "e";
      3'd5:    c = "r";
      default: c = "y";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] dist_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "D";
      4'd1:    c = "i";
      4'd2:    c = "s";
      4'd3:    c = "t";
      4'd4:    c = "a";
      4'd5:    c = "n";
      4'd6:    c = "c";
      default: c = "e";
    endcase
    return c;
  endfunction

  // Prefix text, "Move," "Turn," "Delay,"
  function automatic logic [7:0] pfx_char(input logic [1:0] kind, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    unique case (kind)
      PFX_MOVE: begin
        unique case (pos)
          3'd0:    c = "M";
          3'd1:    c = "o";
          3'd2:    c = "v";
          3'd3:    c = "e";
          3'd4:    c = ",";
          default: c = 8'h00;
        endcase
      end
      PFX_TURN: begin
        unique case (pos)
          3'd0:    c = "T";
          3'd1:    c = "u";
          3'd2:    c = "r";
          3'd3:    c = "n";
          3'd4:    c = ",";
          default: c = 8'h00;
        endcase
      end
      default: begin
        unique case (pos)
          3'd0:    c = "D";
          3'd1:    c = "e";
          3'd2:    c = "l";
          3'd3:    c = "a";
          3'd4:    c = "y";
          3'd5:    c = ",";
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [2:0] pfx_len(input logic [1:0] kind);
    return (kind == PFX_DELAY) ? 3'd6 : 3'd5;
  endfunction

endpackage

// ----- rtl/core/text_command_line_parser.sv -----
// ----------------------------------------------------------------------------
// text_command_line_parser
// Decodes received text lines into commands with a signed argument.
//
//   channel  | handshake         | payload
//   ---------+-------------------+---------------------------------------------
//   input    | push / full       | rx_byte_i
//   result   | pop / empty       | command_kind_o, argument_o, argument_saturated_o
//
// One byte is taken every cycle while full is low; each matcher advances
// once per byte. After its line feed is taken, a result passes the input
// stage, the queue and the result register in that order; it can be popped
// once it is in the result register.
// Reset clears all line state and empties queue and result register.
// While a result waits, text bytes flow until a line feed reaches the queue
// head and waits there; full rises once the queue and input stage are both occupied.
// ----------------------------------------------------------------------------
module text_command_line_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         command_kind_o,
  output logic signed [31:0] argument_o,
  output logic               argument_saturated_o
);
  import tlp_pkg::*;

  logic   front_valid;
  token_t front_tok;
  logic   q_full, q_empty, back_take;
  token_t q_tok;

  // Front: classification stage
  tlp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .rx_byte_i   (rx_byte_i),
    .tok_valid_o (front_valid),
    .tok_o       (front_tok),
    .q_full_i    (q_full)
  );

  // Decoupling queue
  tlp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .wdata_i (front_tok),
    .full_o  (q_full),
    .pop_i   (back_take),
    .rdata_o (q_tok),
    .empty_o (q_empty)
  );

  // Back: matchers and result register
  tlp_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .tok_valid_i          (!q_empty),
    .tok_i                (q_tok),
    .tok_take_o           (back_take),
    .empty                (empty),
    .pop                  (pop),
    .command_kind_o       (command_kind_o),
    .argument_o           (argument_o),
    .argument_saturated_o (argument_saturated_o)
  );

endmodule

// ----- rtl/core/tlp_front.sv -----
// ----------------------------------------------------------------------------
// tlp_front
// Input stage: takes raw bytes, drops carriage returns, tags the class.
// ----------------------------------------------------------------------------
module tlp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [7:0]      rx_byte_i,
  output logic            tok_valid_o,
  output tlp_pkg::token_t tok_o,
  input  logic            q_full_i
);
  import tlp_pkg::*;

  logic      tok_valid_q, tok_valid_d;
  token_t    tok_q;
  char_cls_e cls;
  logic      accept;

  // Byte classification
  always_comb begin
    priority if (rx_byte_i == 8'h0A) begin
      cls = CLS_EOL;
    end else if (rx_byte_i == 8'h0D) begin
      cls = CLS_CR;
    end else if (rx_byte_i == 8'h00) begin
      cls = CLS_NUL;
    end else if (rx_byte_i >= "0" && rx_byte_i <= "9") begin
      cls = CLS_DIGIT;
    end else if (rx_byte_i == " " || rx_byte_i == 8'h09 ||
                 rx_byte_i == 8'h0B || rx_byte_i == 8'h0C) begin
      cls = CLS_BLANK;
    end else if (rx_byte_i == "+" || rx_byte_i == "-") begin
      cls = CLS_SIGN;
    end else begin
      cls = CLS_TEXT;
    end
  end

  // Holding stage; it drains into the queue whenever the queue has room
  assign full   = tok_valid_q && q_full_i;
  assign accept = push && !full;

  always_comb begin
    if (accept) begin
      tok_valid_d = (cls != CLS_CR);
    end else begin
      tok_valid_d = tok_valid_q && q_full_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tok_q.cls <= cls;
      tok_q.ch  <= rx_byte_i;
    end
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;

endmodule

// ----- rtl/core/tlp_queue.sv -----
// ----------------------------------------------------------------------------
// tlp_queue
// Short register queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
`include "text_command_line_parser_macros.svh"

module tlp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tlp_pkg::token_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output tlp_pkg::token_t rdata_o,
  output logic            empty_o
);
  import tlp_pkg::*;

  token_t                 mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic                   do_push, do_pop;

  assign full_o  = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Checks
  `TLP_ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count over depth")
  `TLP_ASSERT_NEXT(a_cnt_down, clk_i, rst_ni, do_pop && !do_push, cnt_q == $past(cnt_q) - 1'b1, "count did not fall")
  `TLP_ASSERT_NEXT(a_cnt_up, clk_i, rst_ni, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1, "count did not rise")

endmodule

// ----- rtl/core/tlp_back.sv -----
// ----------------------------------------------------------------------------
// tlp_back
// Keyword and number matchers; decodes one command per line feed.
// ----------------------------------------------------------------------------
`include "text_command_line_parser_macros.svh"

module tlp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tok_valid_i,
  input  tlp_pkg::token_t    tok_i,
  output logic               tok_take_o,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         command_kind_o,
  output logic signed [31:0] argument_o,
  output logic               argument_saturated_o
);
  import tlp_pkg::*;

  logic [LEN_W-1:0] len_q, len_d;
  logic             ended_q, ended_d;
  logic [2:0]       stop_q, stop_d;
  logic [2:0]       batt_q, batt_d;
  logic [3:0]       dist_q, dist_d;
  logic [2:0]       pos_q, pos_d;
  logic [1:0]       kind_q, kind_d;
  phase_e           phase_q, phase_d;
  logic [31:0]      mag_q, mag_d;
  logic             neg_q, neg_d;
  logic             clamp_q, clamp_d;

  logic             out_valid_q, out_valid_d;
  cmd_e             out_kind_q, out_kind_d;
  logic [31:0]      out_arg_q, out_arg_d;
  logic             out_sat_q, out_sat_d;

  logic [7:0]       ch;
  logic             is_eol;
  logic             take;
  logic [35:0]      dig_sum, dig_lim;
  logic [31:0]      dig_mag;
  logic             dig_clamp;
  logic [1:0]       kind_n;
  logic             first_ok;

  assign ch         = tok_i.ch;
  assign is_eol     = (tok_i.cls == CLS_EOL);
  // A line feed needs a free result slot; other bytes go straight through
  assign take       = tok_valid_i && (!is_eol || !out_valid_q || pop);
  assign tok_take_o = take;

  // Next magnitude: mag * 10 + digit, clamped to the signed range
  always_comb begin
    dig_sum   = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + {32'b0, ch[3:0]};
    dig_lim   = neg_q ? LIMIT_NEG : LIMIT_POS;
    dig_clamp = (dig_sum > dig_lim);
    dig_mag   = dig_clamp ? dig_lim[31:0] : dig_sum[31:0];
  end

  // Prefix kind chosen by the first byte
  always_comb begin
    first_ok = 1'b1;
    kind_n   = kind_q;
    if (pos_q == 3'd0) begin
      priority if (ch == "M") begin
        kind_n = PFX_MOVE;
      end else if (ch == "T") begin
        kind_n = PFX_TURN;
      end else if (ch == "D") begin
        kind_n = PFX_DELAY;
      end else begin
        first_ok = 1'b0;
      end
    end
  end

  // Line state update
  always_comb begin
    len_d       = len_q;
    ended_d     = ended_q;
    stop_d      = stop_q;
    batt_d      = batt_q;
    dist_d      = dist_q;
    pos_d       = pos_q;
    kind_d      = kind_q;
    phase_d     = phase_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    clamp_d     = clamp_q;
    out_valid_d = out_valid_q && !pop;
    out_kind_d  = out_kind_q;
    out_arg_d   = out_arg_q;
    out_sat_d   = out_sat_q;

    if (take && is_eol) begin
      // Decode in priority order, then clear the line
      out_valid_d = 1'b1;
      out_arg_d   = '0;
      out_sat_d   = 1'b0;
      priority if (len_q == LEN_W'(MAX_LINE)) begin
        out_kind_d = CMD_OVERLONG;
      end else if (stop_q == 3'(STOP_LEN)) begin
        out_kind_d = CMD_STOP;
      end else if (batt_q == 3'(BATT_LEN)) begin
        out_kind_d = CMD_BATTERY;
      end else if (dist_q == 4'(DIST_LEN)) begin
        out_kind_d = CMD_DISTANCE;
      end else if (phase_q == PH_DIGITS || phase_q == PH_DONE) begin
        unique case (kind_q)
          PFX_MOVE: out_kind_d = CMD_MOVE;
          PFX_TURN: out_kind_d = CMD_TURN;
          default:  out_kind_d = CMD_DELAY;
        endcase
        out_arg_d = neg_q ? (32'd0 - mag_q) : mag_q;
        out_sat_d = clamp_q;
      end else begin
        out_kind_d = CMD_UNKNOWN;
      end
      len_d   = '0;
      ended_d = 1'b0;
      stop_d  = '0;
      batt_d  = '0;
      dist_d  = '0;
      pos_d   = '0;
      kind_d  = '0;
      phase_d = PH_PREFIX;
      mag_d   = '0;
      neg_d   = 1'b0;
      clamp_d = 1'b0;
    end else if (take) begin
      if (len_q != LEN_W'(MAX_LINE)) begin
        len_d = len_q + 1'b1;
      end
      if (!ended_q) begin
        if (tok_i.cls == CLS_NUL) begin
          ended_d = 1'b1;
        end else begin
          // Keyword matchers; no keyword repeats its first letter
          if (stop_q != 3'(STOP_LEN)) begin
            stop_d = (ch == stop_char(stop_q)) ? stop_q + 1'b1 :
                     (ch == "S") ? 3'd1 : 3'd0;
          end
          if (batt_q != 3'(BATT_LEN)) begin
            batt_d = (ch == batt_char(batt_q)) ? batt_q + 1'b1 :
                     (ch == "B") ? 3'd1 : 3'd0;
          end
          if (dist_q != 4'(DIST_LEN)) begin
            dist_d = (ch == dist_char(dist_q)) ? dist_q + 1'b1 :
                     (ch == "D") ? 4'd1 : 4'd0;
          end

          // Number parser
          unique case (phase_q)
            PH_PREFIX: begin
              kind_d = kind_n;
              if (!first_ok || ch != pfx_char(kind_n, pos_q)) begin
                phase_d = PH_FAIL;
              end else begin
                pos_d = pos_q + 1'b1;
                if (pos_q + 1'b1 == pfx_len(kind_n)) begin
                  phase_d = PH_BLANKS;
                end
              end
            end
            PH_BLANKS: begin
              priority if (tok_i.cls == CLS_BLANK) begin
                phase_d = PH_BLANKS;
              end else if (tok_i.cls == CLS_SIGN) begin
                neg_d   = (ch == "-");
                phase_d = PH_SIGNED;
              end else if (tok_i.cls == CLS_DIGIT) begin
                mag_d   = dig_mag;
                clamp_d = clamp_q | dig_clamp;
                phase_d = PH_DIGITS;
              end else begin
                phase_d = PH_FAIL;
              end
            end
            PH_SIGNED, PH_DIGITS: begin
              if (tok_i.cls == CLS_DIGIT) begin
                mag_d   = dig_mag;
                clamp_d = clamp_q | dig_clamp;
                phase_d = PH_DIGITS;
              end else begin
                phase_d = (phase_q == PH_DIGITS) ? PH_DONE : PH_FAIL;
              end
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ended_q     <= 1'b0;
      stop_q      <= '0;
      batt_q      <= '0;
      dist_q      <= '0;
      pos_q       <= '0;
      kind_q      <= '0;
      phase_q     <= PH_PREFIX;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      clamp_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      ended_q     <= ended_d;
      stop_q      <= stop_d;
      batt_q      <= batt_d;
      dist_q      <= dist_d;
      pos_q       <= pos_d;
      kind_q      <= kind_d;
      phase_q     <= phase_d;
      mag_q       <= mag_d;
      neg_q       <= neg_d;
      clamp_q     <= clamp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_arg_q  <= out_arg_d;
    out_sat_q  <= out_sat_d;
  end

  assign empty                = !out_valid_q;
  assign command_kind_o       = out_kind_q;
  assign argument_o           = out_arg_q;
  assign argument_saturated_o = out_sat_q;

  // Checks
  `TLP_ASSERT_ALWAYS(a_len_bound, clk_i, rst_ni, len_q <= LEN_W'(MAX_LINE), "line length past limit")
  `TLP_ASSERT_IMPLIES(a_clamp_phase, clk_i, rst_ni, clamp_q, phase_q == PH_DIGITS || phase_q == PH_DONE, "clamp outside number")
  `TLP_ASSERT_IMPLIES(a_ended_len, clk_i, rst_ni, ended_q, len_q != '0, "text ended on empty line")
  `TLP_ASSERT_IMPLIES(a_arg_zero, clk_i, rst_ni, out_valid_q && out_kind_q != CMD_MOVE && out_kind_q != CMD_TURN && out_kind_q != CMD_DELAY, out_arg_q == '0 && !out_sat_q, "argument on plain command")

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives text lines byte by byte into the command line parser and checks
// every decoded command against a line decoder kept in the bench. Covers
// keywords, numbered commands, saturation, NUL and carriage return handling,
// overlong lines and random traffic with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import tlp_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 7;
  localparam int MAX_WAIT     = 17;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_BYTES = 900;
  localparam int SETTLE_CYCLES = 10;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Keyword and prefix text, last character in the low byte
  localparam logic [63:0] WORD_STOP  = "Stop";
  localparam logic [63:0] WORD_BATT  = "Battery";
  localparam logic [63:0] WORD_DIST  = "Distance";
  localparam logic [63:0] WORD_MOVE  = "Move,";
  localparam logic [63:0] WORD_TURN  = "Turn,";
  localparam logic [63:0] WORD_DELAY = "Delay,";

  typedef struct packed {
    cmd_e               kind;
    logic signed [31:0] arg;
    logic               sat;
  } line_cmd_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [7:0]         rx_byte = 8'h00;
  logic               empty;
  logic               pop = 1'b0;
  logic [2:0]         command_kind;
  logic signed [31:0] argument;
  logic               argument_sat;

  // Commands decoded by the bench, oldest first
  line_cmd_t  pending_cmds[$];
  line_cmd_t  expected_cmd;
  logic [7:0] line_buf[$];
  int         error_count = 0;
  int         result_count = 0;
  int         accepted_bytes = 0;
  int         idle_cycles = 0;
  logic       push_steady = 1'b0;
  logic       pop_steady = 1'b0;

  logic [7:0] blank_chars [4] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};
  string      big_numbers [5] = '{"2147483647", "2147483648", "2147483649",
                                  "99999999999", "000000000002147483647"};

  // Line decoder state
  int unsigned line_len;
  logic        text_done;
  logic [2:0]  stop_seen;
  logic [2:0]  batt_seen;
  logic [3:0]  dist_seen;
  logic [2:0]  pfx_pos;
  logic [1:0]  pfx_kind;
  phase_e      num_phase;
  logic [31:0] num_mag;
  logic        num_neg;
  logic        num_clamp;

  text_command_line_parser u_top (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .push                 (push),
    .full                 (full),
    .rx_byte_i            (rx_byte),
    .empty                (empty),
    .pop                  (pop),
    .command_kind_o       (command_kind),
    .argument_o           (argument),
    .argument_saturated_o (argument_sat)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Line decoder
  // ---------------------------------------------------------------------------
  function automatic void clear_line_state();
    line_len  = 0;
    text_done = 1'b0;
    stop_seen = '0;
    batt_seen = '0;
    dist_seen = '0;
    pfx_pos   = '0;
    pfx_kind  = PFX_MOVE;
    num_phase = PH_PREFIX;
    num_mag   = '0;
    num_neg   = 1'b0;
    num_clamp = 1'b0;
  endfunction

  // No keyword repeats its first letter, so a miss restarts at 0 or 1
  function automatic logic [3:0] keyword_step(input logic [3:0] seen, input logic [63:0] word,
                                              input int len, input logic [7:0] c);
    if (seen >= len) return 4'(len);
    if (c == word[8*(len-1-seen) +: 8]) return seen + 4'd1;
    return (c == word[8*(len-1) +: 8]) ? 4'd1 : 4'd0;
  endfunction

  function automatic void add_digit(input logic [7:0] c);
    logic [63:0] acc;
    logic [63:0] lim;
    lim = num_neg ? 64'd2147483648 : 64'd2147483647;
    acc = {32'd0, num_mag} * 64'd10 + {56'd0, c - 8'h30};
    if (acc > lim) begin
      acc = lim;
      num_clamp = 1'b1;
    end
    num_mag = acc[31:0];
  endfunction

  function automatic void number_step(input logic [7:0] c);
    logic [63:0] word;
    int          plen;
    logic        is_digit;
    is_digit = (c >= "0") && (c <= "9");
    case (num_phase)
      PH_PREFIX: begin
        if (pfx_pos == 0) begin
          if (c == "M") pfx_kind = PFX_MOVE;
          else if (c == "T") pfx_kind = PFX_TURN;
          else if (c == "D") pfx_kind = PFX_DELAY;
          else begin
            num_phase = PH_FAIL;
            return;
          end
        end
        plen = (pfx_kind == PFX_DELAY) ? 6 : 5;
        word = (pfx_kind == PFX_MOVE) ? WORD_MOVE :
               (pfx_kind == PFX_TURN) ? WORD_TURN : WORD_DELAY;
        if (c != word[8*(plen-1-pfx_pos) +: 8]) begin
          num_phase = PH_FAIL;
        end else begin
          pfx_pos = pfx_pos + 3'd1;
          if (pfx_pos == plen) num_phase = PH_BLANKS;
        end
      end
      PH_BLANKS: begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) begin
          // blanks before the number are skipped
        end else if (c == "+" || c == "-") begin
          num_neg   = (c == "-");
          num_phase = PH_SIGNED;
        end else if (is_digit) begin
          add_digit(c);
          num_phase = PH_DIGITS;
        end else begin
          num_phase = PH_FAIL;
        end
      end
      PH_SIGNED: begin
        if (is_digit) begin
          add_digit(c);
          num_phase = PH_DIGITS;
        end else begin
          num_phase = PH_FAIL;
        end
      end
      PH_DIGITS: begin
        if (is_digit) add_digit(c);
        else num_phase = PH_DONE;
      end
      default: ;
    endcase
  endfunction

  // Returns 1 when the byte closes a line and yields a command
  function automatic logic decode_byte(input logic [7:0] c, output line_cmd_t cmd);
    cmd.kind = CMD_UNKNOWN;
    cmd.arg  = '0;
    cmd.sat  = 1'b0;
    if (c == CH_CR) return 1'b0;
    if (c != CH_LF) begin
      if (line_len < MAX_LINE) line_len++;
      if (!text_done) begin
        if (c == CH_NUL) begin
          text_done = 1'b1;
        end else begin
          stop_seen = 3'(keyword_step({1'b0, stop_seen}, WORD_STOP, STOP_LEN, c));
          batt_seen = 3'(keyword_step({1'b0, batt_seen}, WORD_BATT, BATT_LEN, c));
          dist_seen = keyword_step(dist_seen, WORD_DIST, DIST_LEN, c);
          number_step(c);
        end
      end
      return 1'b0;
    end
    if (line_len >= MAX_LINE) begin
      cmd.kind = CMD_OVERLONG;
    end else if (stop_seen == STOP_LEN) begin
      cmd.kind = CMD_STOP;
    end else if (batt_seen == BATT_LEN) begin
      cmd.kind = CMD_BATTERY;
    end else if (dist_seen == DIST_LEN) begin
      cmd.kind = CMD_DISTANCE;
    end else if (num_phase == PH_DIGITS || num_phase == PH_DONE) begin
      case (pfx_kind)
        PFX_MOVE: cmd.kind = CMD_MOVE;
        PFX_TURN: cmd.kind = CMD_TURN;
        default:  cmd.kind = CMD_DELAY;
      endcase
      cmd.arg = num_neg ? -num_mag : num_mag;
      cmd.sat = num_clamp;
    end
    clear_line_state();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  // One byte request; push is left high so a following byte can go back to back
  task automatic send_byte(input logic [7:0] b);
    int        gap;
    line_cmd_t cmd;
    gap = push_steady ? 0 : $urandom_range(0, MAX_WAIT);
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
    accepted_bytes++;
    if (decode_byte(b, cmd)) pending_cmds.push_back(cmd);
  endtask

  // Stop sending and wait for every outstanding command
  task automatic drain_results();
    @(negedge clk);
    push <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic finish_line();
    line_buf.push_back(CH_LF);
    foreach (line_buf[i]) send_byte(line_buf[i]);
    line_buf.delete();
  endtask

  task automatic send_line(input string s);
    add_text(s);
    finish_line();
  endtask

  function automatic logic [7:0] junk_byte();
    string      pool;
    logic [7:0] b;
    pool = "StopBatteryDistanceMoveTurnDelay,+-0123456789 ";
    case ($urandom_range(0, 2))
      0:       b = pool[$urandom_range(0, pool.len() - 1)];
      1:       b = 8'("0" + $urandom_range(0, 9));
      default: b = 8'($urandom_range(0, 255));
    endcase
    if (b == CH_LF) b = ~b;
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_keywords();
    send_line("Stop");
    send_line("xxBatteryzz");
    send_line("Distance");
    send_line("SStop");
    send_line("BatterDistance");
    send_line("Move,5 Stop");
    send_line("Distance Battery");
    send_line("Stp");
  endtask

  task automatic test_numbers();
    send_line("Move,123");
    send_line("Turn,-45abc");
    send_line("Delay,+0");
    send_line("Move,2147483647");
    send_line("Move,2147483648");
    send_line("Turn,-2147483648");
    send_line("Delay,-99999999999");
    add_text("Move,");
    line_buf.push_back(CH_TAB);
    line_buf.push_back(CH_VT);
    line_buf.push_back(CH_FF);
    line_buf.push_back(CH_SPACE);
    add_text("7");
    finish_line();
    send_line("Move,-x");
    send_line("Delay,");
    send_line("Move, +");
    send_line("move,1");
    send_line("Dela,1");
    send_line("Move;1");
  endtask

  task automatic test_special_bytes();
    send_line("");
    add_text("Sto");
    line_buf.push_back(CH_NUL);
    send_line("p");
    line_buf.push_back(CH_NUL);
    send_line("Stop");
    add_text("Mo");
    line_buf.push_back(CH_CR);
    add_text("ve,1");
    line_buf.push_back(CH_CR);
    finish_line();
    line_buf.push_back(8'hff);
    line_buf.push_back(8'h80);
    line_buf.push_back(8'h7f);
    finish_line();
    line_buf.push_back(CH_CR);
    finish_line();
    add_text("Turn,");
    line_buf.push_back(CH_NUL);
    send_line("5");
    add_text("Delay,42");
    line_buf.push_back(CH_NUL);
    send_line("Stop");
  endtask

  // Length limit: NULs count, carriage returns do not
  task automatic test_overlong();
    push_steady = 1'b1;
    repeat (MAX_LINE - 1) line_buf.push_back("a");
    finish_line();
    repeat (MAX_LINE) line_buf.push_back("a");
    finish_line();
    add_text("Stop");
    repeat (MAX_LINE - 4) line_buf.push_back("b");
    finish_line();
    add_text("Move,1");
    repeat (MAX_LINE - 7) line_buf.push_back(CH_CR);
    repeat (MAX_LINE - 7) line_buf.push_back("9");
    finish_line();
    repeat (MAX_LINE) line_buf.push_back(CH_NUL);
    finish_line();
    repeat (MAX_LINE + 30) line_buf.push_back("c");
    finish_line();
    push_steady = 1'b0;
  endtask

  // Back-to-back short lines against a stalling receiver fill the queue
  task automatic test_backlog();
    push_steady = 1'b1;
    pop_steady  = 1'b0;
    repeat (20) send_line("");
    repeat (5) send_line("Turn,-1");
    push_steady = 1'b0;
    drain_results();
  endtask

  task automatic test_random_lines();
    int start_bytes;
    int pick;
    int digits;
    string word;
    start_bytes = accepted_bytes;
    while (accepted_bytes - start_bytes < RANDOM_BYTES) begin
      push_steady = ($urandom_range(0, 3) == 0);
      pop_steady  = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // numbered command
        case ($urandom_range(0, 2))
          0:       add_text("Move,");
          1:       add_text("Turn,");
          default: add_text("Delay,");
        endcase
        repeat ($urandom_range(0, 2)) line_buf.push_back(blank_chars[$urandom_range(0, 3)]);
        case ($urandom_range(0, 2))
          0:       ;
          1:       line_buf.push_back("+");
          default: line_buf.push_back("-");
        endcase
        if ($urandom_range(0, 7) == 0) begin
          add_text(big_numbers[$urandom_range(0, 4)]);
        end else begin
          digits = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 6);
          repeat (digits) line_buf.push_back(8'("0" + $urandom_range(0, 9)));
        end
        repeat ($urandom_range(0, 4)) line_buf.push_back(junk_byte());
        if ($urandom_range(0, 9) == 0)
          line_buf[$urandom_range(0, line_buf.size() - 1)] = junk_byte();
      end else if (pick < 60) begin
        // keyword somewhere in the line, sometimes cut short
        case ($urandom_range(0, 2))
          0:       word = "Stop";
          1:       word = "Battery";
          default: word = "Distance";
        endcase
        if ($urandom_range(0, 3) == 0) word = word.substr(0, $urandom_range(0, word.len() - 2));
        repeat ($urandom_range(0, 5)) line_buf.push_back(junk_byte());
        add_text(word);
        repeat ($urandom_range(0, 5)) line_buf.push_back(junk_byte());
      end else if (pick < 85) begin
        repeat ($urandom_range(0, 15)) line_buf.push_back(junk_byte());
      end else if (pick < 96) begin
        repeat ($urandom_range(0, 2)) line_buf.push_back(CH_CR);
      end else begin
        if ($urandom_range(0, 1) == 0) add_text("Stop");
        repeat ($urandom_range(MAX_LINE - 6, MAX_LINE + 5)) line_buf.push_back(junk_byte());
      end
      // stray NUL or carriage return
      if (line_buf.size() != 0 && $urandom_range(0, 9) == 0)
        line_buf.insert($urandom_range(0, line_buf.size() - 1), CH_NUL);
      if (line_buf.size() != 0 && $urandom_range(0, 9) == 0)
        line_buf.insert($urandom_range(0, line_buf.size() - 1), CH_CR);
      finish_line();
      if ($urandom_range(0, 49) == 0) drain_results();
    end
    push_steady = 1'b0;
    pop_steady  = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random pop stalls
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    @(posedge rst_n);
    forever begin
      stall = pop_steady ? 0 : $urandom_range(0, MAX_WAIT);
      @(negedge clk);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // Compare each popped command with the oldest decoded one
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      result_count++;
      if (pending_cmds.size() == 0) begin
        report_mismatch($sformatf("result %0d with no line waiting", result_count));
      end else begin
        expected_cmd = pending_cmds.pop_front();
        if (command_kind !== expected_cmd.kind)
          report_mismatch($sformatf("result %0d: kind %0d, want %0d", result_count,
                                    command_kind, expected_cmd.kind));
        if (argument !== expected_cmd.arg)
          report_mismatch($sformatf("result %0d: argument %0d, want %0d", result_count,
                                    argument, expected_cmd.arg));
        if (argument_sat !== expected_cmd.sat)
          report_mismatch($sformatf("result %0d: saturated %0b, want %0b", result_count,
                                    argument_sat, expected_cmd.sat));
      end
    end
  end

  // Watchdog on cycles without any accepted request
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_line_state();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    test_keywords();
    test_numbers();
    test_special_bytes();
    test_overlong();
    test_backlog();
    test_random_lines();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- text_command_line_parser.f -----
+incdir+rtl/core
rtl/core/tlp_pkg.sv
rtl/core/tlp_front.sv
rtl/core/tlp_queue.sv
rtl/core/tlp_back.sv
rtl/core/text_command_line_parser.sv
dv/testbench.sv
